// File: rtl/rfa_pkg.sv
// ----------------------------------------------------------------------------
// rfa_pkg: shared definitions for the rational fraction ALU
// Widths, operation and compare codes, the record handed from the
// operand front end to the reduction pipeline, and the response record.
// ----------------------------------------------------------------------------
package rfa_pkg;

   localparam int OPERAND_BITS = 16;

   localparam int NUM_W     = OPERAND_BITS;
   localparam int DEN_W     = NUM_W - 1;
   localparam int X_W       = NUM_W + 1;
   localparam int PROD_W    = 2 * X_W;
   localparam int MAG_W     = 2 * NUM_W - 1;
   localparam int K_W       = $clog2(MAG_W + 1);
   localparam int GCD_STEPS = 2 * MAG_W;

   localparam int MODE_W    = 3;
   localparam int RES_NUM_W = 32;
   localparam int RES_DEN_W = 30;
   localparam int ORDER_W   = 2;

   localparam int REQ_DATA_W = ((2 * NUM_W + 2 * DEN_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((RES_NUM_W + RES_DEN_W + ORDER_W + 7) / 8) * 8;

   localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CMP = 3'd4;

   localparam logic [ORDER_W-1:0] ORDER_LESS    = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_GREATER = 2'd2;

   typedef struct packed {
      logic                 do_red;
      logic                 neg;
      logic                 err;
      logic [ORDER_W-1:0]   ord;
      logic [MAG_W-1:0]     mag;
      logic [MAG_W-1:0]     den;
      logic [RES_NUM_W-1:0] pass_num;
      logic [RES_DEN_W-1:0] pass_den;
   } red_type;

   typedef struct packed {
      logic [RES_NUM_W-1:0] res_num;
      logic [RES_DEN_W-1:0] res_den;
      logic [ORDER_W-1:0]   order;
      logic                 div_error;
   } rsp_type;

endpackage

// File: rtl/rfa_reduce.sv
// ----------------------------------------------------------------------------
// rfa_reduce: pipelined gcd reduction
// Binary gcd over the numerator magnitude and denominator, one step per
// stage, then exact division of both by the gcd, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rfa_reduce (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             red_valid,
   input  rfa_pkg::red_type red_data,
   output logic             out_valid,
   output rfa_pkg::rsp_type out_data
);

   typedef struct packed {
      rfa_pkg::red_type            r;
      logic [rfa_pkg::MAG_W-1:0]   u;
      logic [rfa_pkg::MAG_W-1:0]   v;
      logic [rfa_pkg::K_W-1:0]     k;
   } gcd_type;

   typedef struct packed {
      rfa_pkg::red_type            r;
      logic [rfa_pkg::MAG_W-1:0]   g;
      logic [rfa_pkg::MAG_W-1:0]   rem_n;
      logic [rfa_pkg::MAG_W-1:0]   dq_n;
      logic [rfa_pkg::MAG_W-1:0]   rem_d;
      logic [rfa_pkg::MAG_W-1:0]   dq_d;
   } div_type;

   function automatic gcd_type gcd_init(rfa_pkg::red_type r);
      gcd_type s;
      s.r = r;
      s.u = r.do_red ? r.mag : '0;
      s.v = r.do_red ? r.den : '0;
      s.k = '0;
      return s;
   endfunction

   function automatic gcd_type gcd_step(gcd_type s);
      if (s.u != '0 && s.v != '0) begin
         if (!s.u[0] && !s.v[0]) begin
            s.u = s.u >> 1;
            s.v = s.v >> 1;
            s.k = s.k + 1'b1;
         end else if (!s.u[0]) begin
            s.u = s.u >> 1;
         end else if (!s.v[0]) begin
            s.v = s.v >> 1;
         end else if (s.u >= s.v) begin
            s.u = (s.u - s.v) >> 1;
         end else begin
            s.v = (s.v - s.u) >> 1;
         end
      end
      return s;
   endfunction

   function automatic div_type div_init(gcd_type s);
      div_type d;
      d.r     = s.r;
      d.g     = (s.u | s.v) << s.k;
      d.rem_n = '0;
      d.dq_n  = s.r.mag;
      d.rem_d = '0;
      d.dq_d  = s.r.den;
      return d;
   endfunction

   function automatic div_type div_step(div_type d);
      logic [rfa_pkg::MAG_W:0] tn;
      logic [rfa_pkg::MAG_W:0] td;
      tn = {d.rem_n, d.dq_n[rfa_pkg::MAG_W-1]};
      td = {d.rem_d, d.dq_d[rfa_pkg::MAG_W-1]};
      if (tn >= {1'b0, d.g}) begin
         d.rem_n = rfa_pkg::MAG_W'(tn - {1'b0, d.g});
         d.dq_n  = {d.dq_n[rfa_pkg::MAG_W-2:0], 1'b1};
      end else begin
         d.rem_n = tn[rfa_pkg::MAG_W-1:0];
         d.dq_n  = {d.dq_n[rfa_pkg::MAG_W-2:0], 1'b0};
      end
      if (td >= {1'b0, d.g}) begin
         d.rem_d = rfa_pkg::MAG_W'(td - {1'b0, d.g});
         d.dq_d  = {d.dq_d[rfa_pkg::MAG_W-2:0], 1'b1};
      end else begin
         d.rem_d = td[rfa_pkg::MAG_W-1:0];
         d.dq_d  = {d.dq_d[rfa_pkg::MAG_W-2:0], 1'b0};
      end
      return d;
   endfunction

   function automatic rfa_pkg::rsp_type finish(div_type d);
      rfa_pkg::rsp_type        o;
      logic [rfa_pkg::RES_NUM_W-1:0] q;
      q = rfa_pkg::RES_NUM_W'(d.dq_n);
      o.order     = d.r.ord;
      o.div_error = d.r.err;
      if (d.r.do_red) begin
         o.res_num = d.r.neg ? (~q + 1'b1) : q;
         o.res_den = rfa_pkg::RES_DEN_W'(d.dq_d);
      end else begin
         o.res_num = d.r.pass_num;
         o.res_den = d.r.pass_den;
      end
      return o;
   endfunction

   gcd_type gs_ff [0:rfa_pkg::GCD_STEPS-1];
   gcd_type gs_in [0:rfa_pkg::GCD_STEPS-1];
   logic [rfa_pkg::GCD_STEPS-1:0] gv_ff;

   div_type dv_ff [0:rfa_pkg::MAG_W-1];
   div_type dv_in [0:rfa_pkg::MAG_W-1];
   logic [rfa_pkg::MAG_W-1:0] dvv_ff;

   rfa_pkg::rsp_type out_ff;
   rfa_pkg::rsp_type out_in;
   logic             out_v_ff;

   for (genvar i = 0; i < rfa_pkg::GCD_STEPS; i++) begin : g_gcd
      if (i == 0) begin : g_first
         assign gs_in[i] = gcd_step(gcd_init(red_data));
      end else begin : g_next
         assign gs_in[i] = gcd_step(gs_ff[i-1]);
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            gs_ff[i] <= gs_in[i];
         end
      end
   end

   for (genvar i = 0; i < rfa_pkg::MAG_W; i++) begin : g_div
      if (i == 0) begin : g_first
         assign dv_in[i] = div_step(div_init(gs_ff[rfa_pkg::GCD_STEPS-1]));
      end else begin : g_next
         assign dv_in[i] = div_step(dv_ff[i-1]);
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            dv_ff[i] <= dv_in[i];
         end
      end
   end

   assign out_in = finish(dv_ff[rfa_pkg::MAG_W-1]);

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gv_ff    <= '0;
         dvv_ff   <= '0;
         out_v_ff <= 1'b0;
      end else if (advance) begin
         gv_ff    <= {gv_ff[rfa_pkg::GCD_STEPS-2:0], red_valid};
         dvv_ff   <= {dvv_ff[rfa_pkg::MAG_W-2:0], gv_ff[rfa_pkg::GCD_STEPS-1]};
         out_v_ff <= dvv_ff[rfa_pkg::MAG_W-1];
      end
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_ff;

endmodule

// File: rtl/rational_fraction_alu_unit.sv
// ----------------------------------------------------------------------------
// rational_fraction_alu_unit: add, subtract, multiply, divide, compare
// Two signed fractions in, one result out. Sums and differences are taken
// over a common denominator; products and quotients are reduced by the gcd.
//
//   channel   dir   handshake            payload
//   req       in    req_tvalid/tready    tdata operands, tuser mode
//   rsp       out   rsp_tvalid/tready    tdata result, tuser divide error
//
// One transaction enters per cycle while the output is not stalled. The
// binary gcd chain (62 stages) and the bit-serial exact divide (31 stages)
// follow the 15-stage divisibility divider and two multiply/combine stages.
// All stages advance together; a stalled output holds every stage in place.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module rational_fraction_alu_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // num_a, den_a, num_b, den_b, zero pad
   input  logic [rfa_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic [rfa_pkg::MODE_W-1:0]     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // res_num, res_den, order
   output logic [rfa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // div_error
   output logic                           rsp_tuser
);

   typedef struct packed {
      logic [rfa_pkg::MODE_W-1:0]       mode;
      logic signed [rfa_pkg::NUM_W-1:0] na;
      logic signed [rfa_pkg::NUM_W-1:0] nb;
      logic [rfa_pkg::DEN_W-1:0]        da;
      logic [rfa_pkg::DEN_W-1:0]        db;
      logic [rfa_pkg::DEN_W-1:0]        dq1;
      logic [rfa_pkg::DEN_W-1:0]        r1;
      logic [rfa_pkg::DEN_W-1:0]        dq2;
      logic [rfa_pkg::DEN_W-1:0]        r2;
   } front_type;

   typedef struct packed {
      logic [rfa_pkg::MODE_W-1:0]        mode;
      logic                              t1;
      logic                              t2;
      logic                              nb_zero;
      logic                              nb_neg;
      logic [rfa_pkg::DEN_W-1:0]         da;
      logic [rfa_pkg::DEN_W-1:0]         db;
      logic signed [rfa_pkg::PROD_W-1:0] p1;
      logic signed [rfa_pkg::PROD_W-1:0] p2;
      logic signed [rfa_pkg::PROD_W-1:0] p3;
   } mul_type;

   // da / db into dq1, r1 and db / da into dq2, r2, one bit per stage
   function automatic front_type div_step(front_type f);
      logic [rfa_pkg::DEN_W:0] t1;
      logic [rfa_pkg::DEN_W:0] t2;
      t1 = {f.r1, f.dq1[rfa_pkg::DEN_W-1]};
      t2 = {f.r2, f.dq2[rfa_pkg::DEN_W-1]};
      if (t1 >= {1'b0, f.db}) begin
         f.r1  = rfa_pkg::DEN_W'(t1 - {1'b0, f.db});
         f.dq1 = {f.dq1[rfa_pkg::DEN_W-2:0], 1'b1};
      end else begin
         f.r1  = t1[rfa_pkg::DEN_W-1:0];
         f.dq1 = {f.dq1[rfa_pkg::DEN_W-2:0], 1'b0};
      end
      if (t2 >= {1'b0, f.da}) begin
         f.r2  = rfa_pkg::DEN_W'(t2 - {1'b0, f.da});
         f.dq2 = {f.dq2[rfa_pkg::DEN_W-2:0], 1'b1};
      end else begin
         f.r2  = t2[rfa_pkg::DEN_W-1:0];
         f.dq2 = {f.dq2[rfa_pkg::DEN_W-2:0], 1'b0};
      end
      return f;
   endfunction

   logic advance;

   front_type               fr_ff [0:rfa_pkg::DEN_W];
   front_type               fr_in [0:rfa_pkg::DEN_W];
   logic [rfa_pkg::DEN_W:0] fv_ff;

   mul_type mul_ff;
   mul_type mul_in;
   logic    mul_v_ff;

   rfa_pkg::red_type red_ff;
   rfa_pkg::red_type red_in;
   logic             red_v_ff;

   logic             out_valid;
   rfa_pkg::rsp_type out_data;

   assign advance    = !out_valid || rsp_tready;
   assign req_tready = advance;

   // capture operands
   always_comb begin
      fr_in[0]      = '0;
      fr_in[0].mode = req_tuser;
      fr_in[0].na   = req_tdata[0 +: rfa_pkg::NUM_W];
      fr_in[0].da   = req_tdata[rfa_pkg::NUM_W +: rfa_pkg::DEN_W];
      fr_in[0].nb   = req_tdata[rfa_pkg::NUM_W + rfa_pkg::DEN_W +: rfa_pkg::NUM_W];
      fr_in[0].db   = req_tdata[2 * rfa_pkg::NUM_W + rfa_pkg::DEN_W +: rfa_pkg::DEN_W];
      fr_in[0].dq1  = fr_in[0].da;
      fr_in[0].dq2  = fr_in[0].db;
   end

   for (genvar i = 1; i <= rfa_pkg::DEN_W; i++) begin : g_front
      assign fr_in[i] = div_step(fr_ff[i-1]);
   end

   for (genvar i = 0; i <= rfa_pkg::DEN_W; i++) begin : g_front_reg
      always_ff @(posedge clock) begin
         if (advance) begin
            fr_ff[i] <= fr_in[i];
         end
      end
   end

   // pick multiplicands per operation
   always_comb begin
      front_type                      f;
      logic                           t1;
      logic                           t2;
      logic signed [rfa_pkg::X_W-1:0] a1;
      logic signed [rfa_pkg::X_W-1:0] a2;
      logic signed [rfa_pkg::X_W-1:0] a3;
      logic signed [rfa_pkg::X_W-1:0] x1;
      logic signed [rfa_pkg::X_W-1:0] x2;
      logic signed [rfa_pkg::X_W-1:0] x3;
      f  = fr_ff[rfa_pkg::DEN_W];
      t1 = (f.db != '0) && (f.r1 == '0);
      t2 = !t1 && (f.da != '0) && (f.r2 == '0);
      a1 = rfa_pkg::X_W'(f.na);
      a2 = rfa_pkg::X_W'(f.nb);
      a3 = rfa_pkg::X_W'(f.da);
      x1 = '0;
      x2 = '0;
      x3 = '0;
      case (f.mode)
         rfa_pkg::MODE_ADD, rfa_pkg::MODE_SUB, rfa_pkg::MODE_CMP: begin
            x1 = t1 ? rfa_pkg::X_W'(1) : (t2 ? rfa_pkg::X_W'(f.dq2) : rfa_pkg::X_W'(f.db));
            x2 = t1 ? rfa_pkg::X_W'(f.dq1) : (t2 ? rfa_pkg::X_W'(1) : rfa_pkg::X_W'(f.da));
            x3 = rfa_pkg::X_W'(f.db);
         end
         rfa_pkg::MODE_MUL: begin
            x1 = a2;
            x3 = rfa_pkg::X_W'(f.db);
         end
         rfa_pkg::MODE_DIV: begin
            x1 = rfa_pkg::X_W'(f.db);
            x3 = f.nb[rfa_pkg::NUM_W-1] ? (rfa_pkg::X_W'(0) - a2) : a2;
         end
         default: begin
            x1 = '0;
         end
      endcase
      mul_in.mode    = f.mode;
      mul_in.t1      = t1;
      mul_in.t2      = t2;
      mul_in.nb_zero = (f.nb == '0);
      mul_in.nb_neg  = f.nb[rfa_pkg::NUM_W-1];
      mul_in.da      = f.da;
      mul_in.db      = f.db;
      mul_in.p1      = a1 * x1;
      mul_in.p2      = a2 * x2;
      mul_in.p3      = a3 * x3;
   end

   // form the sum, difference, order or the value to reduce
   always_comb begin
      logic signed [rfa_pkg::PROD_W-1:0] p1;
      logic signed [rfa_pkg::PROD_W-1:0] p2;
      logic signed [rfa_pkg::PROD_W:0]   sum;
      logic signed [rfa_pkg::PROD_W:0]   dif;
      logic signed [rfa_pkg::PROD_W-1:0] rn;
      logic [rfa_pkg::MAG_W-1:0]         den;
      p1  = mul_ff.p1;
      p2  = mul_ff.p2;
      sum = (rfa_pkg::PROD_W+1)'(p1) + (rfa_pkg::PROD_W+1)'(p2);
      dif = (rfa_pkg::PROD_W+1)'(p1) - (rfa_pkg::PROD_W+1)'(p2);
      rn  = (mul_ff.mode == rfa_pkg::MODE_DIV && mul_ff.nb_neg) ? -p1 : p1;
      den = mul_ff.t1 ? rfa_pkg::MAG_W'(mul_ff.da) :
            (mul_ff.t2 ? rfa_pkg::MAG_W'(mul_ff.db) : rfa_pkg::MAG_W'(mul_ff.p3));
      red_in = '0;
      case (mul_ff.mode)
         rfa_pkg::MODE_ADD: begin
            red_in.pass_num = rfa_pkg::RES_NUM_W'(sum);
            red_in.pass_den = rfa_pkg::RES_DEN_W'(den);
         end
         rfa_pkg::MODE_SUB: begin
            red_in.pass_num = rfa_pkg::RES_NUM_W'(dif);
            red_in.pass_den = rfa_pkg::RES_DEN_W'(den);
         end
         rfa_pkg::MODE_MUL, rfa_pkg::MODE_DIV: begin
            if (mul_ff.mode == rfa_pkg::MODE_DIV && mul_ff.nb_zero) begin
               red_in.err = 1'b1;
            end else begin
               red_in.do_red   = (rn != '0) && (mul_ff.p3 != '0);
               red_in.neg      = rn[rfa_pkg::PROD_W-1];
               red_in.mag      = rfa_pkg::MAG_W'(rn[rfa_pkg::PROD_W-1] ? -rn : rn);
               red_in.den      = rfa_pkg::MAG_W'(mul_ff.p3);
               red_in.pass_num = rfa_pkg::RES_NUM_W'(rn);
               red_in.pass_den = rfa_pkg::RES_DEN_W'(mul_ff.p3);
            end
         end
         rfa_pkg::MODE_CMP: begin
            red_in.ord = (p1 < p2) ? rfa_pkg::ORDER_LESS :
                         ((p1 > p2) ? rfa_pkg::ORDER_GREATER : rfa_pkg::ORDER_EQUAL);
         end
         default: begin
            red_in.err = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_ff <= mul_in;
         red_ff <= red_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff    <= '0;
         mul_v_ff <= 1'b0;
         red_v_ff <= 1'b0;
      end else if (advance) begin
         fv_ff    <= {fv_ff[rfa_pkg::DEN_W-1:0], req_tvalid};
         mul_v_ff <= fv_ff[rfa_pkg::DEN_W];
         red_v_ff <= mul_v_ff;
      end
   end

   rfa_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .red_valid (red_v_ff),
      .red_data  (red_ff),
      .out_valid (out_valid),
      .out_data  (out_data)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = rfa_pkg::RSP_DATA_W'({out_data.order, out_data.res_den,
                                              out_data.res_num});
   assign rsp_tuser  = out_data.div_error;

endmodule
